### hdl/symbol_string_hash64_unit_macros.svh
// assertion macros for the string hash unit
// used by the top level; expects signals named clock and reset in scope
`ifndef SYMBOL_STRING_HASH64_UNIT_MACROS_SVH
`define SYMBOL_STRING_HASH64_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define SH64_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define SH64_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/sh64_pkg.sv
// shared types and constants for the string hash unit
// no dependencies; used by sh64_mul_unit and symbol_string_hash64_unit
`default_nettype none

package sh64_pkg;

   localparam int HASH_W     = 64;
   localparam int HALF_W     = HASH_W / 2;
   localparam int BYTE_W     = 8;
   localparam int COUNT_W    = 3;
   localparam int STEP_W     = 2;
   localparam int MIX_SHIFT  = 33;
   localparam int TAIL_SHIFT = 5;   // h*33 = (h << 5) + h

   localparam logic [HASH_W-1:0]  MIX_MUL_A      = 64'hff51afd7ed558ccd;
   localparam logic [HASH_W-1:0]  MIX_MUL_B      = 64'hc4ceb9fe1a85ec53;
   localparam logic [COUNT_W-1:0] LAST_SLOT      = 3'd7;
   localparam logic [STEP_W-1:0]  MIX_LAST_STEP  = 2'd2;

   // sequencer states
   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_XSHIFT = 6'b000010,
      ST_MUL0   = 6'b000100,
      ST_MUL1   = 6'b001000,
      ST_MUL2   = 6'b010000,
      ST_TAIL   = 6'b100000
   } state_type;

   // which 32x32 partial product the multiplier forms
   typedef enum logic [1:0] {
      MUL_PH_LL = 2'd0,   // low half of h times low half of constant
      MUL_PH_HL = 2'd1,   // high half of h times low half of constant
      MUL_PH_LH = 2'd2    // low half of h times high half of constant
   } mul_phase_type;

   // control from the sequencer to the multiplier
   typedef struct packed {
      logic          active;
      logic          const_sel;   // 0 selects MIX_MUL_A, 1 selects MIX_MUL_B
      mul_phase_type phase;
   } mul_ctl_type;

endpackage

`default_nettype wire

### hdl/symbol_string_hash64_unit.sv
// Streaming 64-bit string hash: one byte per item in, one hash per string out.
// Input items arrive on req_*: tdata carries data_byte, tuser carries has_byte,
// tlast marks the final item of a string. An item with has_byte low and tlast
// high ends a string without adding a byte (an empty string hashes to zero).
// The hash leaves on rsp_* as a 64-bit tdata, one item per string.
// A byte that does not complete a group of eight is taken without a stall,
// so such items are taken back to back. A byte that completes a group starts
// the mix: three xor-shifts and two 64-bit multiplies, each multiply being
// three passes through one shared 32x32 multiplier, and req_tready stays low
// throughout the mix. The final item then leads to the tail step, which
// folds in each leftover tail byte (0 to 7) and then loads the output register.
// rsp_tvalid rises after the mix, if the last byte completed a group, and the
// tail steps; the load waits while the output register still holds a result.
// The output register holds the hash while rsp_tready is low; the next string
// may start meanwhile, and its result waits until the register is free.
// Synchronous reset clears the hash state, the sequencer and rsp_tvalid.
// Depends on sh64_pkg, sh64_mul_unit and symbol_string_hash64_unit_macros.svh.
`default_nettype none
`include "symbol_string_hash64_unit_macros.svh"

module symbol_string_hash64_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,    // [7:0] data_byte
   input  wire logic        req_tuser,    // [0] has_byte
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata     // [63:0] hash_value
);

   sh64_pkg::state_type                  state_ff, state_in;
   logic [sh64_pkg::HASH_W-1:0]          hash_ff, hash_in;
   logic [sh64_pkg::HASH_W-1:0]          pend_ff, pend_in;
   logic [sh64_pkg::COUNT_W-1:0]         count_ff, count_in;
   logic [sh64_pkg::STEP_W-1:0]          step_ff, step_in;
   logic                                 fin_ff, fin_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [sh64_pkg::HASH_W-1:0]          rsp_data_ff, rsp_data_in;
   logic                                 req_accept;
   sh64_pkg::mul_ctl_type                mul_ctl;
   logic [sh64_pkg::HASH_W-1:0]          mul_result;
   logic [sh64_pkg::HASH_W-1:0]          tail_byte;

   assign req_tready = (state_ff == sh64_pkg::ST_IDLE);
   assign req_accept = req_tvalid & req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // oldest pending byte, sign-extended
   assign tail_byte = {{(sh64_pkg::HASH_W-sh64_pkg::BYTE_W){pend_ff[sh64_pkg::BYTE_W-1]}},
                       pend_ff[sh64_pkg::BYTE_W-1:0]};

   // shared multiplier
   sh64_mul_unit u_mul (
      .clock  (clock),
      .ctl    (mul_ctl),
      .hash   (hash_ff),
      .result (mul_result)
   );

   // sequencer and datapath next state
   always_comb begin
      state_in      = state_ff;
      hash_in       = hash_ff;
      pend_in       = pend_ff;
      count_in      = count_ff;
      step_in       = step_ff;
      fin_in        = fin_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_data_in   = rsp_data_ff;
      mul_ctl.active    = 1'b0;
      mul_ctl.const_sel = step_ff[0];
      mul_ctl.phase     = sh64_pkg::MUL_PH_LL;

      case (state_ff)
         sh64_pkg::ST_IDLE: begin
            if (req_accept) begin
               fin_in = req_tlast;
               if (req_tuser) begin
                  if (count_ff == sh64_pkg::LAST_SLOT) begin
                     // group complete: fold it in and start the mix
                     hash_in  = hash_ff ^ {req_tdata,
                                           pend_ff[sh64_pkg::HASH_W-sh64_pkg::BYTE_W-1:0]};
                     pend_in  = '0;
                     count_in = '0;
                     step_in  = '0;
                     state_in = sh64_pkg::ST_XSHIFT;
                  end else begin
                     for (int i = 0; i < sh64_pkg::HASH_W / sh64_pkg::BYTE_W; i++) begin
                        if (count_ff == sh64_pkg::COUNT_W'(i)) begin
                           pend_in[i*sh64_pkg::BYTE_W +: sh64_pkg::BYTE_W] = req_tdata;
                        end
                     end
                     count_in = sh64_pkg::COUNT_W'(count_ff + 1'b1);
                     if (req_tlast) begin
                        state_in = sh64_pkg::ST_TAIL;
                     end
                  end
               end else if (req_tlast) begin
                  state_in = sh64_pkg::ST_TAIL;
               end
            end
         end
         sh64_pkg::ST_XSHIFT: begin
            hash_in = hash_ff ^ (hash_ff >> sh64_pkg::MIX_SHIFT);
            if (step_ff == sh64_pkg::MIX_LAST_STEP) begin
               state_in = fin_ff ? sh64_pkg::ST_TAIL : sh64_pkg::ST_IDLE;
            end else begin
               state_in = sh64_pkg::ST_MUL0;
            end
         end
         sh64_pkg::ST_MUL0: begin
            mul_ctl.active = 1'b1;
            mul_ctl.phase  = sh64_pkg::MUL_PH_LL;
            state_in       = sh64_pkg::ST_MUL1;
         end
         sh64_pkg::ST_MUL1: begin
            mul_ctl.active = 1'b1;
            mul_ctl.phase  = sh64_pkg::MUL_PH_HL;
            state_in       = sh64_pkg::ST_MUL2;
         end
         sh64_pkg::ST_MUL2: begin
            mul_ctl.active = 1'b1;
            mul_ctl.phase  = sh64_pkg::MUL_PH_LH;
            hash_in        = mul_result;
            step_in        = sh64_pkg::STEP_W'(step_ff + 1'b1);
            state_in       = sh64_pkg::ST_XSHIFT;
         end
         sh64_pkg::ST_TAIL: begin
            if (count_ff != '0) begin
               // h = h*33 + signed byte, oldest byte first
               hash_in  = hash_ff + (hash_ff << sh64_pkg::TAIL_SHIFT) + tail_byte;
               pend_in  = pend_ff >> sh64_pkg::BYTE_W;
               count_in = sh64_pkg::COUNT_W'(count_ff - 1'b1);
            end else if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = hash_ff;
               hash_in      = '0;
               pend_in      = '0;
               fin_in       = 1'b0;
               state_in     = sh64_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sh64_pkg::ST_IDLE;
         end
      endcase
   end

   // control and hash state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sh64_pkg::ST_IDLE;
         hash_ff      <= '0;
         pend_ff      <= '0;
         count_ff     <= '0;
         step_ff      <= '0;
         fin_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hash_ff      <= hash_in;
         pend_ff      <= pend_in;
         count_ff     <= count_in;
         step_ff      <= step_in;
         fin_ff       <= fin_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   // checks
   `SH64_ASSERT_NXT(a_group_starts_mix,
      req_accept && req_tuser && (count_ff == sh64_pkg::LAST_SLOT),
      state_ff == sh64_pkg::ST_XSHIFT && hash_ff == $past(hash_ff ^ {req_tdata, pend_ff[55:0]}),
      "completed group did not start the mix")
   `SH64_ASSERT_NXT(a_mul_returns_to_shift,
      state_ff == sh64_pkg::ST_MUL2,
      state_ff == sh64_pkg::ST_XSHIFT && step_ff == $past(step_ff) + 2'd1,
      "multiply did not hand back to the xor-shift step")
   `SH64_ASSERT_NXT(a_tail_consumes_byte,
      state_ff == sh64_pkg::ST_TAIL && count_ff != 3'd0,
      count_ff == $past(count_ff) - 3'd1 && state_ff == sh64_pkg::ST_TAIL,
      "tail step did not consume one byte")
   `SH64_ASSERT_IMP(a_step_in_range,
      state_ff != sh64_pkg::ST_IDLE && state_ff != sh64_pkg::ST_TAIL,
      step_ff != 2'd3,
      "mix step counter out of range")

endmodule

`default_nettype wire

### hdl/sh64_mul_unit.sv
// shared 32x32 multiplier that builds a 64-bit wrapping product over its LL, HL and LH phases
// depends on sh64_pkg
`default_nettype none

module sh64_mul_unit (
   input  wire logic                         clock,
   input  wire sh64_pkg::mul_ctl_type        ctl,
   input  wire logic [sh64_pkg::HASH_W-1:0]  hash,
   output logic      [sh64_pkg::HASH_W-1:0]  result
);

   logic [sh64_pkg::HASH_W-1:0] coef;
   logic [sh64_pkg::HALF_W-1:0] op_a;
   logic [sh64_pkg::HALF_W-1:0] op_b;
   logic [sh64_pkg::HASH_W-1:0] prod;
   logic [sh64_pkg::HASH_W-1:0] part_ff;
   logic [sh64_pkg::HASH_W-1:0] part_in;
   logic [sh64_pkg::HALF_W-1:0] upper_sum;

   // operand selection for the current partial product
   always_comb begin
      coef = ctl.const_sel ? sh64_pkg::MIX_MUL_B : sh64_pkg::MIX_MUL_A;
      case (ctl.phase)
         sh64_pkg::MUL_PH_LL: begin
            op_a = hash[sh64_pkg::HALF_W-1:0];
            op_b = coef[sh64_pkg::HALF_W-1:0];
         end
         sh64_pkg::MUL_PH_HL: begin
            op_a = hash[sh64_pkg::HASH_W-1:sh64_pkg::HALF_W];
            op_b = coef[sh64_pkg::HALF_W-1:0];
         end
         sh64_pkg::MUL_PH_LH: begin
            op_a = hash[sh64_pkg::HALF_W-1:0];
            op_b = coef[sh64_pkg::HASH_W-1:sh64_pkg::HALF_W];
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   assign prod = sh64_pkg::HASH_W'(op_a) * sh64_pkg::HASH_W'(op_b);

   // cross products only reach the upper half mod 2^64
   assign upper_sum = part_ff[sh64_pkg::HASH_W-1:sh64_pkg::HALF_W] +
                      prod[sh64_pkg::HALF_W-1:0];

   always_comb begin
      case (ctl.phase)
         sh64_pkg::MUL_PH_LL: part_in = prod;
         sh64_pkg::MUL_PH_HL: part_in = {upper_sum, part_ff[sh64_pkg::HALF_W-1:0]};
         default:             part_in = part_ff;
      endcase
   end

   // partial sum register
   always_ff @(posedge clock) begin
      if (ctl.active) begin
         part_ff <= part_in;
      end
   end

   // final product, valid during the last phase
   assign result = {upper_sum, part_ff[sh64_pkg::HALF_W-1:0]};

endmodule

`default_nettype wire
